[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/bb3_pkg.sv]
package bb3_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DIM_RESET      = 1024;

  localparam int CH_W        = 8;
  localparam int SUM_W       = 12;          // nine 8-bit terms
  localparam int CNT_W       = 4;           // neighbour count, 1..9
  localparam int DIV_W       = SUM_W + 1;   // 2*sum + count
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = DIV_W + RECIP_W;

  typedef struct packed {
    logic            opcode;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_in_frame;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // which neighbours of the centre lie inside the frame
  typedef struct packed {
    logic             top_ok;
    logic             bot_ok;
    logic             lft_ok;
    logic             rgt_ok;
    logic [CNT_W-1:0] cnt;
  } win_ctl_t;

  typedef struct packed {
    logic     step;   // window column shifts in
    logic     emit;   // a result leaves for this step
    logic     last;
    logic     par;    // parity of the input row being stepped
    win_ctl_t win;
  } s1_ctl_t;

  // ceil(2^17 / (2*cnt)); exact floor for every dividend below 4600
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[rtl/box_blur_3x3_rgb.sv]
// 3x3 box blur on an RGB pixel stream. Pixels enter in raster order, one
// transaction each (opcode pixel); each output pixel is the per-channel mean
// of its in-frame 3x3 neighbours, rounded half up, so edges and corners
// average 6 or 4 pixels. The result for a pixel leaves when the pixel one row
// and one column further on is taken, so after the frame's last pixel the
// source sends drain transactions (opcode drain) to flush the last row plus
// one; each drain gives one result and the frame's final result carries
// last_in_frame, after which the next pixel starts a new frame. A drain with
// nothing pending, or one sent before the frame is complete, gives nothing;
// a pixel sent while results are still pending is dropped and acts as a drain.
// Throughput is one transaction per clock while in_ready is high: the two
// line stores are single-port, read-first RAMs touched once per transaction,
// and the three colour lanes work side by side. A result passes the line
// store read, the window sum and the reciprocal divide into the output
// register before it reaches out_valid. in_ready drops only while a result
// sits unaccepted at the output, and after the last pixel of a single-row
// frame while the window loads its first column. The line stores need
// no clearing after reset. frame_width and frame_height (index 0 and 1)
// clamp to 1..MAX_WIDTH / 1..MAX_HEIGHT and restart the frame, discarding
// pending results; write them only when idle.
`include "assert_macros.svh"

module box_blur_3x3_rgb import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                 en;
  logic [AW-1:0]        mem_addr;
  logic                 wr_en, wr_sel, rd_en;
  s1_ctl_t              s1;
  pix_t                 in_pix, px_r, rd_even, rd_odd, row_top, row_mid;
  logic [2:0][CH_W-1:0] col_red, col_green, col_blue;
  logic                 shift;
  logic [CH_W-1:0]      q_red, q_green, q_blue;
  logic                 s2_emit_r, s2_last_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // whole pipe advances unless a finished result is held at the output
  assign en = !out_valid_r || out_ready;

  bb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .mem_addr  (mem_addr),
    .wr_en     (wr_en),
    .wr_sel    (wr_sel),
    .rd_en     (rd_en),
    .s1        (s1)
  );

  assign in_pix = {in_data.red_in, in_data.green_in, in_data.blue_in};

  // rows alternate between the two stores by parity; a new row overwrites
  // the row two above it, which is read out in the same clock
  bb3_line_store #(.DEPTH(MAX_WIDTH)) u_store_even (
    .clk     (clk),
    .wr_en   (wr_en && !wr_sel),
    .rd_en   (rd_en),
    .addr    (mem_addr),
    .wdata   (in_pix),
    .rd_data (rd_even)
  );

  bb3_line_store #(.DEPTH(MAX_WIDTH)) u_store_odd (
    .clk     (clk),
    .wr_en   (wr_en && wr_sel),
    .rd_en   (rd_en),
    .addr    (mem_addr),
    .wdata   (in_pix),
    .rd_data (rd_odd)
  );

  // incoming pixel lines up with the store read; unused on drain steps,
  // where the bottom row or the right column falls outside the frame
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= in_pix;
    end
  end

  assign row_top = s1.par ? rd_odd  : rd_even;
  assign row_mid = s1.par ? rd_even : rd_odd;

  assign col_red   = {px_r.red,   row_mid.red,   row_top.red};
  assign col_green = {px_r.green, row_mid.green, row_top.green};
  assign col_blue  = {px_r.blue,  row_mid.blue,  row_top.blue};

  assign shift = en && s1.step;

  bb3_lane u_lane_red (
    .clk     (clk),
    .en      (en),
    .shift   (shift),
    .col_new (col_red),
    .win     (s1.win),
    .q       (q_red)
  );

  bb3_lane u_lane_green (
    .clk     (clk),
    .en      (en),
    .shift   (shift),
    .col_new (col_green),
    .win     (s1.win),
    .q       (q_green)
  );

  bb3_lane u_lane_blue (
    .clk     (clk),
    .en      (en),
    .shift   (shift),
    .col_new (col_blue),
    .win     (s1.win),
    .q       (q_blue)
  );

  // merge: the three lane quotients and the frame marker form one result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_emit_r   <= s1.emit;
      out_valid_r <= s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last_r                <= s1.last;
      out_data_r.red_out       <= q_red;
      out_data_r.green_out     <= q_green;
      out_data_r.blue_out      <= q_blue;
      out_data_r.last_in_frame <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_emit_reaches_output, clk, rst_n, en && s2_emit_r, out_valid)

endmodule

[rtl/bb3_line_store.sv]
module bb3_line_store import bb3_pkg::*; #(
  parameter int  DEPTH = DEF_MAX_WIDTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  pix_t          wdata,
  output pix_t          rd_data
);

  pix_t mem [DEPTH];
  pix_t rd_data_r;

  // read-first: a read and write of one address return the old row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bb3_lane.sv]
module bb3_lane import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  shift,
  input  logic [2:0][CH_W-1:0]  col_new,   // [0] top, [1] middle, [2] bottom
  input  win_ctl_t              win,
  output logic [CH_W-1:0]       q
);

  logic [2:0][CH_W-1:0] col_a_r;   // left column of the window
  logic [2:0][CH_W-1:0] col_b_r;   // centre column
  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     cnt_r;

  logic [2:0]           row_ok;
  logic [SUM_W-1:0]     sum_c;
  logic [DIV_W-1:0]     dividend;
  logic [PROD_W-1:0]    prod;

  always_comb begin
    row_ok = {win.bot_ok, 1'b1, win.top_ok};
    sum_c  = '0;
    for (int i = 0; i < 3; i++) begin
      if (row_ok[i]) begin
        sum_c = sum_c + SUM_W'(col_b_r[i]);
        if (win.lft_ok) sum_c = sum_c + SUM_W'(col_a_r[i]);
        if (win.rgt_ok) sum_c = sum_c + SUM_W'(col_new[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_a_r <= col_b_r;
      col_b_r <= col_new;
    end
    if (en) begin
      sum_r <= sum_c;
      cnt_r <= win.cnt;
    end
  end

  // round half up: (2*sum + n) / (2*n) by reciprocal multiply
  assign dividend = {sum_r, 1'b0} + DIV_W'(cnt_r);
  assign prod     = PROD_W'(dividend) * PROD_W'(recip(cnt_r));
  assign q        = prod[RECIP_SHIFT +: CH_W];

endmodule

[rtl/bb3_ctrl.sv]
`include "assert_macros.svh"

module bb3_ctrl import bb3_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int AW         = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_opcode,
  output logic                 in_ready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic [AW-1:0]        mem_addr,
  output logic                 wr_en,
  output logic                 wr_sel,
  output logic                 rd_en,
  output s1_ctl_t              s1
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = $clog2(MAX_HEIGHT + 2);   // input row runs to height+1 in drain
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam logic [WW-1:0] W_RST = WW'((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET);
  localparam logic [HW-1:0] H_RST = HW'((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET);

  logic [WW-1:0]  w_r, w_nxt;
  logic [HW-1:0]  h_r, h_nxt;
  logic [AW-1:0]  in_col_r, in_col_nxt;
  logic [IRW-1:0] in_row_r, in_row_nxt;
  logic [AW-1:0]  out_col_r, out_col_nxt;
  logic [ORW-1:0] out_row_r, out_row_nxt;
  logic           prime_r, prime_nxt;
  s1_ctl_t        s1_r, s1_nxt;

  logic           acc, input_done, px_step, drain_emit, prime_step, step;
  logic           px_emit, emit, in_col_last, out_col_last, out_row_last, last;
  logic [1:0]     rows_n, cols_n;
  win_ctl_t       win;
  logic [WW-1:0]  dim_w;
  logic [HW-1:0]  dim_h;

  assign in_ready = en && !prime_r;

  // register values out of range clamp to 1..max
  always_comb begin
    if (cfg_wdata == '0) begin
      dim_w = WW'(1);
      dim_h = HW'(1);
    end else begin
      dim_w = (cfg_wdata > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_wdata);
      dim_h = (cfg_wdata > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata);
    end
  end

  always_comb begin
    acc        = in_valid && in_ready;
    input_done = (in_row_r >= h_r);
    px_step    = acc && (in_opcode == OP_PIXEL) && !input_done;
    drain_emit = acc && !px_step && input_done;
    prime_step = en && prime_r;
    step       = px_step || drain_emit || prime_step;
    px_emit    = px_step && ((in_row_r > IRW'(1)) ||
                             ((in_row_r == IRW'(1)) && (in_col_r != '0)));
    emit       = px_emit || drain_emit;

    in_col_last  = (({1'b0, in_col_r} + 1'b1) == w_r);
    out_col_last = (({1'b0, out_col_r} + 1'b1) == w_r);
    out_row_last = (({1'b0, out_row_r} + 1'b1) == h_r);
    last         = out_row_last && out_col_last;

    win.top_ok = (out_row_r != '0);
    win.bot_ok = !out_row_last;
    win.lft_ok = (out_col_r != '0);
    win.rgt_ok = !out_col_last;
    rows_n     = 2'd1 + {1'b0, win.top_ok} + {1'b0, win.bot_ok};
    cols_n     = 2'd1 + {1'b0, win.lft_ok} + {1'b0, win.rgt_ok};
    win.cnt    = {2'b00, rows_n} * {2'b00, cols_n};

    w_nxt       = w_r;
    h_nxt       = h_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    prime_nxt   = prime_r;

    // input position keeps walking through drain so the window slides on
    if (step) begin
      if (in_col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end

    if (emit) begin
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_last) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end

    // single-row frame: window needs column 0 loaded before the first drain
    if (prime_step) prime_nxt = 1'b0;
    if (px_step && (h_r == HW'(1)) && in_col_last) prime_nxt = 1'b1;

    if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH: begin
          w_nxt = dim_w;
        end
        REG_FRAME_HEIGHT: begin
          h_nxt = dim_h;
        end
        default: begin
        end
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      prime_nxt   = 1'b0;
    end

    s1_nxt = s1_r;
    if (en) begin
      s1_nxt.step = step;
      s1_nxt.emit = emit;
      s1_nxt.last = last;
      s1_nxt.par  = in_row_r[0];
      s1_nxt.win  = win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= W_RST;
      h_r       <= H_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      prime_r   <= 1'b0;
      s1_r      <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      prime_r   <= prime_nxt;
      s1_r      <= s1_nxt;
    end
  end

  assign mem_addr = in_col_r;
  assign wr_en    = px_step;
  assign wr_sel   = in_row_r[0];
  assign rd_en    = step;
  assign s1       = s1_r;

  `ASSERT_IMPLIES(a_in_col_in_frame, clk, rst_n, 1'b1, in_col_r < w_r)
  `ASSERT_IMPLIES(a_out_row_in_frame, clk, rst_n, 1'b1, out_row_r < h_r)
  `ASSERT_IMPLIES(a_emit_after_first_row, clk, rst_n, emit, in_row_r != '0)
  `ASSERT_IMPLIES(a_prime_single_row, clk, rst_n, prime_r, h_r == HW'(1))

endmodule
